/* hdl/ffd_pkg.sv */
// Shared types and constants of the free-fall detector.
package ffd_pkg;

  // Window depth and derived widths
  localparam int unsigned WINDOW = 5;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NORM_W = 16;
  localparam int unsigned SUM_W  = NORM_W + CNT_W;

  // Shared multiplier and square root widths
  localparam int unsigned OPND_W = 17;
  localparam int unsigned PROD_W = 2 * OPND_W;
  localparam int unsigned RAD_W  = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TILT_COS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOV_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOV_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_PRIO = 3'd4;

  localparam logic [14:0] TILT_COS_RST  = 15'd11585;
  localparam logic [15:0] FALL_THR_RST  = 16'd4096;
  localparam logic [15:0] RECOV_LOW_RST = 16'd14000;
  localparam logic [15:0] RECOV_HI_RST  = 16'd19000;
  localparam logic [7:0]  FALL_PRIO_RST = 8'd100;

  // Action codes of an input request
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_KILL   = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [15:0] orient_zz;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } ffd_in_t;

  typedef struct packed {
    logic       is_falling;
    logic       priority_update;
    logic [7:0] priority_value;
  } ffd_out_t;

endpackage

/* hdl/ffd_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
module ffd_sqrt import ffd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RAD_W-1:0]    rad_i,
  output logic                done_o,
  output logic [NORM_W-1:0]   root_o
);

  localparam int unsigned ITER_W = $clog2(NORM_W);
  localparam int unsigned REM_W  = NORM_W + 2;
  localparam int unsigned TRY_W  = REM_W + 2;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [ITER_W-1:0]  iter_q, iter_d;
  logic [RAD_W-1:0]   rad_q, rad_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [NORM_W-1:0]  root_q, root_d;
  logic [TRY_W-1:0]   rem_shift;
  logic [TRY_W-1:0]   trial;
  logic [TRY_W-1:0]   diff;

  // Bring down the next bit pair and try the next root bit
  assign rem_shift = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial     = {2'b00, root_q, 2'b01};
  assign diff      = rem_shift - trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_d  = diff[REM_W-1:0];
        root_d = {root_q[NORM_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift[REM_W-1:0];
        root_d = {root_q[NORM_W-2:0], 1'b0};
      end
      iter_d = iter_q + ITER_W'(1);
      if (iter_q == ITER_W'(NORM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* hdl/ffd_window.sv */
// Sliding window of acceleration norms with running sum and fill count.
module ffd_window import ffd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [NORM_W-1:0]  norm_i,
  output logic [SUM_W-1:0]   sum_o,
  output logic [CNT_W-1:0]   count_o
);

  logic [NORM_W-1:0] win_q [WINDOW];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              full;

  assign full = (count_q == CNT_W'(WINDOW));

  // Drop the oldest norm once full, add the new one, advance the slot
  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (push_i) begin
      if (full) begin
        sum_d = sum_q - SUM_W'(win_q[slot_q]) + SUM_W'(norm_i);
      end else begin
        sum_d   = sum_q + SUM_W'(norm_i);
        count_d = count_q + CNT_W'(1);
      end
      slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      slot_q  <= slot_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Slots are read only after they have been written
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q[slot_q] <= norm_i;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count_q;

endmodule

/* hdl/free_fall_detector_hysteresis_core.sv */
// Free-fall detector: a sample request runs multiply-accumulate of the axis squares, square
// root, window push, three threshold compares and output load, in that order; a kill request
// goes straight to the output load, which waits for a free output register. No new request
// is taken until the result is loaded. The shared 17x17 multiplier and bit-serial root serve
// these steps. Reset clears the window, the falling flag and loads register defaults.
module free_fall_detector_hysteresis_core import ffd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ffd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ffd_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT,
    ST_WINDOW,
    ST_COMPARE,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [1:0]         step_q;
  logic [OPND_W-1:0]  mag_q [3];
  logic [OPND_W-1:0]  abs_zz;
  logic               tilt_ok_q;
  logic [RAD_W-1:0]   acc_q;
  logic               lt_fall_q, gt_low_q;
  logic               falling_q;
  ffd_out_t           res_q;
  ffd_out_t           out_q;
  logic               out_valid_q;

  logic [14:0]        tilt_cos_q;
  logic [15:0]        fall_thr_q;
  logic [15:0]        recov_low_q;
  logic [15:0]        recov_hi_q;
  logic [7:0]         fall_prio_q;

  logic [OPND_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  sum_ext;
  logic               sqrt_start, sqrt_done;
  logic [NORM_W-1:0]  norm;
  logic [SUM_W-1:0]   win_sum;
  logic [CNT_W-1:0]   win_cnt;
  logic               win_push;
  logic               accept;
  logic               out_free;

  // Magnitude of a signed 16-bit value, 17 bits wide so that -32768 maps to 32768
  function automatic logic [OPND_W-1:0] mag17(input logic [15:0] a);
    logic [OPND_W-1:0] ext;
    ext = {a[15], a};
    return a[15] ? (~ext + OPND_W'(1)) : ext;
  endfunction

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign abs_zz     = mag17(in_data_i.orient_zz);

  // Shared multiplier: squares of the axes, then thresholds times fill count
  always_comb begin
    mul_a = mag_q[step_q];
    mul_b = mag_q[step_q];
    if (state_q == ST_COMPARE) begin
      case (step_q)
        2'd0:    mul_a = OPND_W'(fall_thr_q);
        2'd1:    mul_a = OPND_W'(recov_low_q);
        default: mul_a = OPND_W'(recov_hi_q);
      endcase
      mul_b = OPND_W'(win_cnt);
    end
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sum_ext = PROD_W'(win_sum);

  assign sqrt_start = (state_q == ST_ROOT_GO);
  assign win_push   = (state_q == ST_WINDOW);

  ffd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_q),
    .done_o  (sqrt_done),
    .root_o  (norm)
  );

  ffd_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (win_push),
    .norm_i  (norm),
    .sum_o   (win_sum),
    .count_o (win_cnt)
  );

  // Configuration registers; indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_cos_q  <= TILT_COS_RST;
      fall_thr_q  <= FALL_THR_RST;
      recov_low_q <= RECOV_LOW_RST;
      recov_hi_q  <= RECOV_HI_RST;
      fall_prio_q <= FALL_PRIO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TILT_COS:  tilt_cos_q  <= cfg_data_i[14:0];
        CFG_FALL_THR:  fall_thr_q  <= cfg_data_i;
        CFG_RECOV_LOW: recov_low_q <= cfg_data_i;
        CFG_RECOV_HI:  recov_hi_q  <= cfg_data_i;
        CFG_FALL_PRIO: fall_prio_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer, falling flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mag_q[0]    <= '0;
      mag_q[1]    <= '0;
      mag_q[2]    <= '0;
      tilt_ok_q   <= 1'b0;
      acc_q       <= '0;
      lt_fall_q   <= 1'b0;
      gt_low_q    <= 1'b0;
      falling_q   <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            step_q    <= '0;
            acc_q     <= '0;
            mag_q[0]  <= mag17(in_data_i.accel_x);
            mag_q[1]  <= mag17(in_data_i.accel_y);
            mag_q[2]  <= mag17(in_data_i.accel_z);
            tilt_ok_q <= (abs_zz < OPND_W'(tilt_cos_q));
            if (in_data_i.action == ACT_KILL) begin
              falling_q <= 1'b0;
              res_q     <= '{is_falling: 1'b0, priority_update: 1'b1,
                             priority_value: 8'd0};
              state_q   <= ST_DONE;
            end else begin
              state_q <= ST_SQUARE;
            end
          end
        end
        ST_SQUARE: begin
          // Accumulate one axis square per cycle
          acc_q <= acc_q + prod[RAD_W-1:0];
          if (step_q == 2'd2) begin
            step_q  <= '0;
            state_q <= ST_ROOT_GO;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        ST_ROOT_GO: begin
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            state_q <= ST_WINDOW;
          end
        end
        ST_WINDOW: begin
          step_q  <= '0;
          state_q <= ST_COMPARE;
        end
        ST_COMPARE: begin
          case (step_q)
            2'd0: begin
              lt_fall_q <= (sum_ext < prod);
              step_q    <= step_q + 2'd1;
            end
            2'd1: begin
              gt_low_q <= (sum_ext > prod);
              step_q   <= step_q + 2'd1;
            end
            default: begin
              // Decide fall, recovery or no announcement
              step_q  <= '0;
              state_q <= ST_DONE;
              if (!falling_q && tilt_ok_q && lt_fall_q) begin
                falling_q <= 1'b1;
                res_q     <= '{is_falling: 1'b1, priority_update: 1'b1,
                               priority_value: fall_prio_q};
              end else if (falling_q && gt_low_q && (sum_ext < prod)) begin
                falling_q <= 1'b0;
                res_q     <= '{is_falling: 1'b0, priority_update: 1'b1,
                               priority_value: 8'd0};
              end else begin
                res_q     <= '{is_falling: falling_q, priority_update: 1'b0,
                               priority_value: 8'd0};
              end
            end
          endcase
        end
        ST_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
